@@ sv/homogeneous_point_transform_core_assert.svh @@
// assertion macros for the homogeneous point transform core
`ifndef HOMOGENEOUS_POINT_TRANSFORM_CORE_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HPTC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define HPTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/hpt_pkg.sv @@
// package: types, constants and divider step for the point transform core
package hpt_pkg;

    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    // row sum width (signed) and magnitude width
    localparam int SUM_W      = 52;
    localparam int MAG_W      = 51;
    // quotient bits produced, one per divider stage
    localparam int DIV_STEPS  = 33;

    localparam logic OP_POINT = 1'b0;
    localparam logic OP_DIR   = 1'b1;

    localparam logic signed [SUM_W-1:0] ONE_Q16 = SUM_W'(32'h0001_0000);

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               saturated;
    } out_item_t;

    // one divider lane: partial remainder, dividend bits shifting out / quotient in
    typedef struct packed {
        logic [MAG_W-1:0]     rem;
        logic [DIV_STEPS-1:0] qn;
        logic                 neg;
        logic                 ovf;
    } div_lane_t;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    function automatic div_lane_t div_step(div_lane_t cur, logic [MAG_W-1:0] aw);
        logic [MAG_W:0] t;
        logic           fits;
        div_lane_t      nxt;
        t    = {cur.rem, cur.qn[DIV_STEPS-1]};
        fits = (t >= {1'b0, aw});
        nxt  = cur;
        nxt.rem = fits ? MAG_W'(t - {1'b0, aw}) : t[MAG_W-1:0];
        nxt.qn  = {cur.qn[DIV_STEPS-2:0], fits};
        return nxt;
    endfunction

endpackage

@@ sv/homogeneous_point_transform_core.sv @@
// top level: pipelined 4x4 homogeneous transform with perspective divide
// One request enters per clock and its result passes through multiply, row sum,
// divide setup, 33 restoring divider steps of one quotient bit each for x, y
// and z in parallel, and saturation into the output register. Throughput is
// one request per cycle; the whole pipeline holds while the output register is
// full and not taken. The user must write the matrix through the configuration
// port only while the core is idle; the core does not enforce this. Reset loads
// the identity. Direction requests run the same path with w fixed to 1.0.
module homogeneous_point_transform_core
    import hpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "homogeneous_point_transform_core_assert.svh"

    logic [CFG_DATA_W-1:0] mat_reg [NUM_REGS];
    logic                  en;

    logic                     s1_valid_reg;
    logic                     s1_op_reg;
    logic signed [63:0]       prod_reg [4][3];
    logic signed [31:0]       tr_reg [4];

    logic                     s2_valid_reg;
    logic                     s2_op_reg;
    logic signed [SUM_W-1:0]  sum_reg [4];
    logic signed [SUM_W-1:0]  sum_next [4];

    div_lane_t                div_reg [DIV_STEPS+1][3];
    logic [MAG_W-1:0]         aw_reg [DIV_STEPS+1];
    logic                     dv_reg [DIV_STEPS+1];

    logic                     out_valid_reg;
    out_item_t                out_reg;
    out_item_t                out_next;

    // pipeline advances whenever the output register can move
    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // matrix entry of column c, row r
    function automatic logic signed [31:0] m_at(int c, int r);
        logic [CFG_DATA_W-1:0] w;
        w = mat_reg[CFG_IDX_W'(2 * c + r / 2)];
        return (r % 2 == 1) ? w[63:32] : w[31:0];
    endfunction

    // matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= 64'h0000_0000_0001_0000;
            mat_reg[1] <= '0;
            mat_reg[2] <= 64'h0001_0000_0000_0000;
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= 64'h0000_0000_0001_0000;
            mat_reg[6] <= '0;
            mat_reg[7] <= 64'h0001_0000_0000_0000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mat_reg[cfg_index] <= cfg_data;
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            dv_reg[0]     <= s2_valid_reg;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
            out_valid_reg <= dv_reg[DIV_STEPS];
        end
    end

    // stage 1: twelve products, translation column gated by opcode
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg <= in_data.opcode;
            for (int r = 0; r < 4; r++)
            begin
                prod_reg[r][0] <= m_at(0, r) * in_data.in_x;
                prod_reg[r][1] <= m_at(1, r) * in_data.in_y;
                prod_reg[r][2] <= m_at(2, r) * in_data.in_z;
                tr_reg[r]      <= (in_data.opcode == OP_POINT) ? m_at(3, r) : 32'sd0;
            end
        end
    end

    // stage 2: floor each product to q16 and sum the rows
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            sum_next[r] = SUM_W'(prod_reg[r][0] >>> 16) + SUM_W'(prod_reg[r][1] >>> 16)
                        + SUM_W'(prod_reg[r][2] >>> 16) + SUM_W'(tr_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_op_reg <= s1_op_reg;
            for (int r = 0; r < 4; r++)
            begin
                sum_reg[r] <= sum_next[r];
            end
        end
    end

    // stage 3: pick w, split signs and magnitudes, detect huge quotients
    always_ff @(posedge clk)
    begin
        logic signed [SUM_W-1:0] w;
        logic [MAG_W-1:0]        aw;
        logic [MAG_W-1:0]        ax;
        if (en)
        begin
            w = (s2_op_reg == OP_DIR || sum_reg[3] == '0) ? ONE_Q16 : sum_reg[3];
            aw = MAG_W'(w[SUM_W-1] ? -w : w);
            aw_reg[0] <= aw;
            for (int r = 0; r < 3; r++)
            begin
                ax = MAG_W'(sum_reg[r][SUM_W-1] ? -sum_reg[r] : sum_reg[r]);
                div_reg[0][r].neg <= sum_reg[r][SUM_W-1] ^ w[SUM_W-1];
                div_reg[0][r].ovf <= ({17'b0, ax} >= {aw, 17'b0});
                div_reg[0][r].rem <= ax >> 17;
                div_reg[0][r].qn  <= {ax[16:0], 16'b0};
            end
        end
    end

    // divider stages, one quotient bit each
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                aw_reg[k+1] <= aw_reg[k];
                for (int r = 0; r < 3; r++)
                begin
                    div_reg[k+1][r] <= div_step(div_reg[k][r], aw_reg[k]);
                end
            end
        end
    end

    // saturate the quotients into the output register
    always_comb
    begin
        logic [31:0]     val [3];
        logic [2:0]      big;
        div_lane_t       ln;
        for (int r = 0; r < 3; r++)
        begin
            ln = div_reg[DIV_STEPS][r];
            if (!ln.neg)
            begin
                big[r] = ln.ovf || (ln.qn > 33'h0_7FFF_FFFF);
                val[r] = big[r] ? 32'h7FFF_FFFF : ln.qn[31:0];
            end
            else
            begin
                big[r] = ln.ovf || (ln.qn > 33'h0_8000_0000);
                val[r] = big[r] ? 32'h8000_0000 : 32'(-ln.qn);
            end
        end
        out_next.out_x     = val[0];
        out_next.out_y     = val[1];
        out_next.out_z     = val[2];
        out_next.saturated = |big;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    // checks
    `HPTC_ASSERT_NEXT(a_enter, in_valid && in_ready, s1_valid_reg, "accepted request lost at entry")
    `HPTC_ASSERT_SAME(a_w_nonzero, dv_reg[0], aw_reg[0] != '0, "divider started with zero w")
    `HPTC_ASSERT_NEXT(a_hold, !en, $stable(dv_reg[DIV_STEPS]) && $stable(s2_valid_reg), "pipeline moved while stalled")

endmodule
